FILE: rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the prescaled reload timer
// Action and register codes, item and result records, counter width.
// ----------------------------------------------------------------------------
package prt_pkg;

    // Width of the main counter, prescale count, prescaler and reload (at most DATA_WIDTH)
    localparam int COUNT_WIDTH = 32;
    localparam int DATA_WIDTH  = 32;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        REG_ENABLE   = 3'd0,
        REG_IRQ_EN   = 3'd1,
        REG_STATUS   = 3'd2,
        REG_EVENT    = 3'd3,
        REG_COUNTER  = 3'd4,
        REG_PRESCALE = 3'd5,
        REG_RELOAD   = 3'd6
    } reg_sel_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic [1:0]            action;
        logic [2:0]            reg_select;
        logic [DATA_WIDTH-1:0] write_data;
    } prt_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  update_event;
        logic                  irq;
    } prt_result_t;

endpackage

FILE: rtl/prt_core.sv
// ----------------------------------------------------------------------------
// prt_core: timer register file and counting logic
// Applies one item per fire strobe to the timer state and returns its result.
// ----------------------------------------------------------------------------
module prt_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  prt_pkg::prt_item_t   item,
    output prt_pkg::prt_result_t result
);
    import prt_pkg::*;

    logic   count_enable_reg, count_enable_next;
    logic   irq_enable_reg,   irq_enable_next;
    logic   update_flag_reg,  update_flag_next;
    count_t main_count_reg,     main_count_next;
    count_t prescale_count_reg, prescale_count_next;
    count_t prescale_limit_reg, prescale_limit_next;
    count_t reload_value_reg,   reload_value_next;

    count_t wdata;
    logic   evt;
    logic [DATA_WIDTH-1:0] rdata;

    assign wdata = item.write_data[COUNT_WIDTH-1:0];

    always_comb
    begin
        count_enable_next   = count_enable_reg;
        irq_enable_next     = irq_enable_reg;
        update_flag_next    = update_flag_reg;
        main_count_next     = main_count_reg;
        prescale_count_next = prescale_count_reg;
        prescale_limit_next = prescale_limit_reg;
        reload_value_next   = reload_value_reg;
        evt                 = 1'b0;
        rdata               = '0;

        case (action_t'(item.action))
            ACT_TICK:
            begin
                if (count_enable_reg)
                begin
                    if (prescale_count_reg != prescale_limit_reg)
                    begin
                        prescale_count_next = prescale_count_reg + count_t'(1);
                    end
                    else
                    begin
                        prescale_count_next = '0;
                        if (main_count_reg == reload_value_reg)
                        begin
                            main_count_next  = '0;
                            update_flag_next = 1'b1;
                            evt              = 1'b1;
                        end
                        else
                        begin
                            main_count_next = main_count_reg + count_t'(1);
                        end
                    end
                end
            end
            ACT_WRITE:
            begin
                case (reg_sel_t'(item.reg_select))
                    REG_ENABLE:   count_enable_next   = item.write_data[0];
                    REG_IRQ_EN:   irq_enable_next     = item.write_data[0];
                    REG_STATUS:   update_flag_next    = item.write_data[0];
                    REG_EVENT:
                    begin
                        if (item.write_data[0])
                        begin
                            main_count_next     = '0;
                            prescale_count_next = '0;
                        end
                    end
                    REG_COUNTER:  main_count_next     = wdata;
                    REG_PRESCALE: prescale_limit_next = wdata;
                    REG_RELOAD:   reload_value_next   = wdata;
                    default:      ;
                endcase
            end
            ACT_READ:
            begin
                case (reg_sel_t'(item.reg_select))
                    REG_ENABLE:   rdata = DATA_WIDTH'(count_enable_reg);
                    REG_IRQ_EN:   rdata = DATA_WIDTH'(irq_enable_reg);
                    REG_STATUS:   rdata = DATA_WIDTH'(update_flag_reg);
                    REG_COUNTER:  rdata = DATA_WIDTH'(main_count_reg);
                    REG_PRESCALE: rdata = DATA_WIDTH'(prescale_limit_reg);
                    REG_RELOAD:   rdata = DATA_WIDTH'(reload_value_reg);
                    default:      rdata = '0;
                endcase
            end
            default: ;
        endcase
    end

    assign result.read_data    = rdata;
    assign result.update_event = evt;
    assign result.irq          = update_flag_next & irq_enable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_enable_reg   <= 1'b0;
            irq_enable_reg     <= 1'b0;
            update_flag_reg    <= 1'b0;
            main_count_reg     <= '0;
            prescale_count_reg <= '0;
            prescale_limit_reg <= '0;
            reload_value_reg   <= '1;
        end
        else if (fire)
        begin
            count_enable_reg   <= count_enable_next;
            irq_enable_reg     <= irq_enable_next;
            update_flag_reg    <= update_flag_next;
            main_count_reg     <= main_count_next;
            prescale_count_reg <= prescale_count_next;
            prescale_limit_reg <= prescale_limit_next;
            reload_value_reg   <= reload_value_next;
        end
    end

    // A disabled tick leaves both counts alone
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == ACT_TICK && !count_enable_reg
        |=> $stable(main_count_reg) && $stable(prescale_count_reg))
        else $error("disabled tick moved a count");

    // An update event leaves both counts at zero and the flag set
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.update_event
        |=> main_count_reg == '0 && prescale_count_reg == '0 && update_flag_reg)
        else $error("update event without wrap");

    // Only writes touch the prescaler and reload registers
    a_limits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action != ACT_WRITE
        |=> $stable(prescale_limit_reg) && $stable(reload_value_reg))
        else $error("limit register changed outside a write");

endmodule

FILE: rtl/prescaled_reload_timer.sv
// ----------------------------------------------------------------------------
// prescaled_reload_timer: up-counting timer with prescaler and auto-reload
// Input register, single-pass register/counter logic, output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per accepted edge:
//   a tick of the timer clock, a register write or a register read, chosen
//   by action, with reg_select and write_data.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   item, in order: read_data, update_event and irq.
//   Order: an accepted item sits in the input register until the output
//   register can take its result; then it is applied to the timer state and
//   its result is on the output ports until taken. Throughput: one item per
//   clock while the receiver does not stall.
//   When the receiver stalls, the output register holds its result; one more
//   item is taken into the input register, then in_stall rises until the
//   output register drains. No item is lost or repeated.
//   Reset (rst_n low, asynchronous) empties both registers and restores the
//   timer: disabled, flag clear, counts and prescaler zero, reload all ones.
// ----------------------------------------------------------------------------
module prescaled_reload_timer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [2:0]                     reg_select,
    input  logic [prt_pkg::DATA_WIDTH-1:0] write_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [prt_pkg::DATA_WIDTH-1:0] read_data,
    output logic                           update_event,
    output logic                           irq
);
    import prt_pkg::*;

    // Input register stage
    logic      s1_valid_reg, s1_valid_next;
    prt_item_t s1_item_reg;

    // Output register stage
    logic        out_valid_reg, out_valid_next;
    prt_result_t out_res_reg;
    prt_result_t core_res;

    logic in_take;   // item taken into the input register
    logic s1_adv;    // held item applied and its result registered

    assign s1_adv  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.action     <= action;
            s1_item_reg.reg_select <= reg_select;
            s1_item_reg.write_data <= write_data;
        end
        if (s1_adv)
            out_res_reg <= core_res;
    end

    prt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_adv),
        .item   (s1_item_reg),
        .result (core_res)
    );

    assign out_valid    = out_valid_reg;
    assign read_data    = out_res_reg.read_data;
    assign update_event = out_res_reg.update_event;
    assign irq          = out_res_reg.irq;

    // Back-pressure only with a held item
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("stall with empty input register");

    // Full pipe with a stalled receiver must push back
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall && s1_valid_reg |-> in_stall)
        else $error("input taken while pipe is full");

    // An applied item always puts its result in the output register
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("applied item produced no result");

endmodule
